// ===== src/pmes_pkg.sv =====
`timescale 1ns / 1ps

package pmes_pkg;

    localparam int MAX_DIM     = 64;
    localparam int STORE_DEPTH = 16384;

    localparam int WORD_W     = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int DIAG_W     = 6;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Band stride 2*kl+ku+1 and the in-column offset kl+ku+r-c.
    localparam int STRIDE_W = DIAG_W + 2;
    localparam int OFF_W    = DIAG_W + 2;
    localparam int PROD_W   = IDX_W + STRIDE_W;
    localparam int SLOT_W   = PROD_W + 1;
    localparam int ADDR_W   = $clog2(STORE_DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_VECTOR    = 3'd0,
        KIND_GENERAL   = 3'd1,
        KIND_SYMMETRIC = 3'd2,
        KIND_DIAGONAL  = 3'd3,
        KIND_UPPER     = 3'd4,
        KIND_LOWER     = 3'd5,
        KIND_BANDED    = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PREC    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_PATTERN = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND    = 3'd0,
        CFG_COMPLEX = 3'd1,
        CFG_ROWS    = 3'd2,
        CFG_COLS    = 3'd3,
        CFG_SUB     = 3'd4,
        CFG_SUPER   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [KIND_W-1:0] matrix_kind;
        logic              is_complex;
        logic [CNT_W-1:0]  row_count;
        logic [CNT_W-1:0]  col_count;
        logic [DIAG_W-1:0] sub_diag_count;
        logic [DIAG_W-1:0] super_diag_count;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic              mode;
        logic              want;
        t_status           status;
        logic [PROD_W-1:0] prod;
        logic [OFF_W-1:0]  off;
        logic [WORD_W-1:0] write_real;
        logic [WORD_W-1:0] write_imag;
    } t_stage;

    typedef struct packed {
        logic              valid;
        logic              mode;
        logic              want;
        t_status           status;
        logic [WORD_W-1:0] rd_real;
        logic [WORD_W-1:0] rd_imag;
    } t_result;

endpackage

// ===== src/pmes_index.sv =====
`timescale 1ns / 1ps

module pmes_index (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_mode,
    input  logic                        i_want_complex,
    input  logic [pmes_pkg::IDX_W-1:0]  i_row_index,
    input  logic [pmes_pkg::IDX_W-1:0]  i_col_index,
    input  logic [pmes_pkg::WORD_W-1:0] i_write_real,
    input  logic [pmes_pkg::WORD_W-1:0] i_write_imag,
    input  pmes_pkg::t_cfg              i_cfg,
    output pmes_pkg::t_stage            o_stage
);

    logic                        r_valid;
    logic                        r_mode;
    logic                        r_want;
    logic [pmes_pkg::IDX_W-1:0]  r_row;
    logic [pmes_pkg::IDX_W-1:0]  r_col;
    logic [pmes_pkg::WORD_W-1:0] r_wr;
    logic [pmes_pkg::WORD_W-1:0] r_wi;
    pmes_pkg::t_stage            r_stage;
    pmes_pkg::t_stage            n_stage;

    logic [pmes_pkg::CNT_W-1:0]    row_ext;
    logic [pmes_pkg::CNT_W-1:0]    col_ext;
    logic [pmes_pkg::CNT_W-1:0]    c_plus_kl;
    logic [pmes_pkg::CNT_W-1:0]    r_plus_ku;
    logic [pmes_pkg::IDX_W-1:0]    lo;
    logic [pmes_pkg::IDX_W-1:0]    hi;
    logic [pmes_pkg::STRIDE_W-1:0] stride;
    logic [pmes_pkg::OFF_W:0]      band_off;
    logic [pmes_pkg::IDX_W-1:0]    op_a;
    logic [pmes_pkg::STRIDE_W-1:0] op_b;
    logic [pmes_pkg::PROD_W-1:0]   prod;
    logic                          halve;
    logic [pmes_pkg::OFF_W-1:0]    off;
    logic                          range_bad;
    logic                          pattern_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_stage.valid <= 1'b0;
        end else begin
            r_valid       <= i_accept;
            r_stage.valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_mode <= i_mode;
            r_want <= i_want_complex;
            r_row  <= i_row_index;
            r_col  <= i_col_index;
            r_wr   <= i_write_real;
            r_wi   <= i_write_imag;
        end
        r_stage.mode       <= n_stage.mode;
        r_stage.want       <= n_stage.want;
        r_stage.status     <= n_stage.status;
        r_stage.prod       <= n_stage.prod;
        r_stage.off        <= n_stage.off;
        r_stage.write_real <= n_stage.write_real;
        r_stage.write_imag <= n_stage.write_imag;
    end

    always_comb begin
        row_ext   = pmes_pkg::CNT_W'(r_row);
        col_ext   = pmes_pkg::CNT_W'(r_col);
        c_plus_kl = col_ext + pmes_pkg::CNT_W'(i_cfg.sub_diag_count);
        r_plus_ku = row_ext + pmes_pkg::CNT_W'(i_cfg.super_diag_count);
        lo        = (r_row < r_col) ? r_row : r_col;
        hi        = (r_row < r_col) ? r_col : r_row;
        stride    = pmes_pkg::STRIDE_W'({i_cfg.sub_diag_count, 1'b0})
                  + pmes_pkg::STRIDE_W'(i_cfg.super_diag_count)
                  + pmes_pkg::STRIDE_W'(1);
        band_off  = (pmes_pkg::OFF_W+1)'(i_cfg.sub_diag_count)
                  + (pmes_pkg::OFF_W+1)'(i_cfg.super_diag_count)
                  + (pmes_pkg::OFF_W+1)'(r_row)
                  - (pmes_pkg::OFF_W+1)'(r_col);

        op_a        = '0;
        op_b        = '0;
        halve       = 1'b0;
        off         = '0;
        pattern_bad = 1'b0;
        unique case (i_cfg.matrix_kind)
            pmes_pkg::KIND_VECTOR: begin
                off = pmes_pkg::OFF_W'(row_ext + col_ext);
            end
            pmes_pkg::KIND_GENERAL: begin
                op_a = r_col;
                op_b = pmes_pkg::STRIDE_W'(i_cfg.row_count);
                off  = pmes_pkg::OFF_W'(r_row);
            end
            pmes_pkg::KIND_SYMMETRIC: begin
                op_a  = hi;
                op_b  = pmes_pkg::STRIDE_W'(hi) + pmes_pkg::STRIDE_W'(1);
                halve = 1'b1;
                off   = pmes_pkg::OFF_W'(lo);
            end
            pmes_pkg::KIND_DIAGONAL: begin
                off         = pmes_pkg::OFF_W'(r_row);
                pattern_bad = (r_row != r_col);
            end
            pmes_pkg::KIND_UPPER, pmes_pkg::KIND_LOWER, pmes_pkg::KIND_BANDED: begin
                op_a        = r_col;
                op_b        = stride;
                off         = band_off[pmes_pkg::OFF_W-1:0];
                pattern_bad = (row_ext > c_plus_kl) || (col_ext > r_plus_ku);
            end
            default: begin
                pattern_bad = 1'b1;
            end
        endcase

        prod = pmes_pkg::PROD_W'(op_a) * pmes_pkg::PROD_W'(op_b);

        range_bad = (row_ext >= i_cfg.row_count) || (col_ext >= i_cfg.col_count)
                 || (32'(r_row) >= 32'(pmes_pkg::MAX_DIM))
                 || (32'(r_col) >= 32'(pmes_pkg::MAX_DIM));

        n_stage.valid      = r_valid;
        n_stage.mode       = r_mode;
        n_stage.want       = r_want;
        n_stage.prod       = halve ? (prod >> 1) : prod;
        n_stage.off        = off;
        n_stage.write_real = r_wr;
        n_stage.write_imag = r_wi;
        priority if (r_want != i_cfg.is_complex) begin
            n_stage.status = pmes_pkg::ST_PREC;
        end else if (range_bad) begin
            n_stage.status = pmes_pkg::ST_RANGE;
        end else if (pattern_bad) begin
            n_stage.status = pmes_pkg::ST_PATTERN;
        end else begin
            n_stage.status = pmes_pkg::ST_OK;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== src/pmes_store.sv =====
`timescale 1ns / 1ps

module pmes_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmes_pkg::t_stage  i_stage,
    output logic              o_busy,
    output pmes_pkg::t_result o_result
);

    logic [pmes_pkg::WORD_W-1:0] mem_real [pmes_pkg::STORE_DEPTH];
    logic [pmes_pkg::WORD_W-1:0] mem_imag [pmes_pkg::STORE_DEPTH];

    logic                        r_clearing;
    logic [pmes_pkg::ADDR_W-1:0] r_clr_addr;
    pmes_pkg::t_result           r_result;

    logic [pmes_pkg::SLOT_W-1:0] slot;
    logic [pmes_pkg::ADDR_W-1:0] addr;
    logic [pmes_pkg::ADDR_W-1:0] wr_addr;
    pmes_pkg::t_status           status;
    logic                        access_ok;
    logic                        we_real;
    logic                        we_imag;
    logic [pmes_pkg::WORD_W-1:0] wd_real;
    logic [pmes_pkg::WORD_W-1:0] wd_imag;

    always_comb begin
        slot   = pmes_pkg::SLOT_W'(i_stage.prod) + pmes_pkg::SLOT_W'(i_stage.off);
        addr   = pmes_pkg::ADDR_W'(slot);
        status = i_stage.status;
        if (i_stage.status == pmes_pkg::ST_OK
                && 32'(slot) >= 32'(pmes_pkg::STORE_DEPTH)) begin
            status = pmes_pkg::ST_PATTERN;
        end
        access_ok = i_stage.valid && (status == pmes_pkg::ST_OK);
        we_real   = r_clearing || (access_ok && i_stage.mode);
        we_imag   = r_clearing || (access_ok && i_stage.mode && i_stage.want);
        wr_addr   = r_clearing ? r_clr_addr : addr;
        wd_real   = r_clearing ? '0 : i_stage.write_real;
        wd_imag   = r_clearing ? '0 : i_stage.write_imag;
    end

    always_ff @(posedge i_clk) begin
        if (we_real) begin
            mem_real[wr_addr] <= wd_real;
        end
        r_result.rd_real <= mem_real[addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_imag) begin
            mem_imag[wr_addr] <= wd_imag;
        end
        r_result.rd_imag <= mem_imag[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing     <= 1'b1;
            r_clr_addr     <= '0;
            r_result.valid <= 1'b0;
        end else begin
            r_result.valid <= i_stage.valid;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + pmes_pkg::ADDR_W'(1);
                if (r_clr_addr == pmes_pkg::ADDR_W'(pmes_pkg::STORE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.mode   <= i_stage.mode;
        r_result.want   <= i_stage.want;
        r_result.status <= status;
    end

    assign o_busy   = r_clearing;
    assign o_result = r_result;

endmodule

// ===== src/packed_matrix_element_store.sv =====
`timescale 1ns / 1ps

// Element store for one matrix held in compact form (vector, column-major general,
// packed symmetric, diagonal, or band layout for the triangular and banded kinds).
// Configuration registers are written through the cfg channel, which is always ready;
// writes are meant to happen only while no item is in flight.
// An item is taken at a clock edge where start is high and busy is low. Every item
// produces exactly one result, shown on the read ports for one cycle with
// o_result_valid high, after the item passes the pipeline registers listed below.
// One item can be taken in every cycle while busy is low; the result path is fully pipelined through
// the input register, the index multiplier stage and the registered memory read.
// A write returns zero data with its status. Failed accesses store nothing.
// After reset the block clears both stores, one entry per cycle, and busy stays high
// until all 16384 entries are cleared; configuration writes are taken during the clear.
// The receiver cannot stall, so results are never held back.

module packed_matrix_element_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic                            i_want_complex,
    input  logic [pmes_pkg::IDX_W-1:0]      i_row_index,
    input  logic [pmes_pkg::IDX_W-1:0]      i_col_index,
    input  logic [pmes_pkg::WORD_W-1:0]     i_write_real,
    input  logic [pmes_pkg::WORD_W-1:0]     i_write_imag,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pmes_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pmes_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_result_valid,
    output logic [pmes_pkg::WORD_W-1:0]     o_read_real,
    output logic [pmes_pkg::WORD_W-1:0]     o_read_imag,
    output logic [pmes_pkg::STATUS_W-1:0]   o_status
);

    pmes_pkg::t_cfg    r_cfg;
    pmes_pkg::t_stage  stage;
    pmes_pkg::t_result result;
    logic              accept;
    logic              clearing;
    logic              read_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.matrix_kind      <= pmes_pkg::KIND_GENERAL;
            r_cfg.is_complex       <= 1'b0;
            r_cfg.row_count        <= pmes_pkg::CNT_W'(1);
            r_cfg.col_count        <= pmes_pkg::CNT_W'(1);
            r_cfg.sub_diag_count   <= '0;
            r_cfg.super_diag_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pmes_pkg::CFG_KIND:
                    r_cfg.matrix_kind      <= i_cfg_data[pmes_pkg::KIND_W-1:0];
                pmes_pkg::CFG_COMPLEX:
                    r_cfg.is_complex       <= i_cfg_data[0];
                pmes_pkg::CFG_ROWS:
                    r_cfg.row_count        <= i_cfg_data[pmes_pkg::CNT_W-1:0];
                pmes_pkg::CFG_COLS:
                    r_cfg.col_count        <= i_cfg_data[pmes_pkg::CNT_W-1:0];
                pmes_pkg::CFG_SUB:
                    r_cfg.sub_diag_count   <= i_cfg_data[pmes_pkg::DIAG_W-1:0];
                pmes_pkg::CFG_SUPER:
                    r_cfg.super_diag_count <= i_cfg_data[pmes_pkg::DIAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign accept      = start && !clearing;
    assign busy        = clearing;
    assign o_cfg_ready = 1'b1;

    pmes_index u_index (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_mode         (i_mode),
        .i_want_complex (i_want_complex),
        .i_row_index    (i_row_index),
        .i_col_index    (i_col_index),
        .i_write_real   (i_write_real),
        .i_write_imag   (i_write_imag),
        .i_cfg          (r_cfg),
        .o_stage        (stage)
    );

    pmes_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (stage),
        .o_busy   (clearing),
        .o_result (result)
    );

    assign read_ok        = (result.status == pmes_pkg::ST_OK) && !result.mode;
    assign o_result_valid = result.valid;
    assign o_read_real    = read_ok ? result.rd_real : '0;
    assign o_read_imag    = (read_ok && result.want) ? result.rd_imag : '0;
    assign o_status       = result.status;

endmodule
